### hw/rtl/lcrt_pkg.sv
// Package for the load-cell ADC readout: phase codes, request and alarm codes,
// register indexes, the sequencer status struct and register reset values.
// No dependencies.
package lcrt_pkg;

    // sequencer phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT  = 3'd1;
    localparam logic [2:0] PH_DHIGH = 3'd2;
    localparam logic [2:0] PH_DLOW  = 3'd3;
    localparam logic [2:0] PH_PHIGH = 3'd4;
    localparam logic [2:0] PH_PLOW  = 3'd5;

    // request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_WEIGHT = 2'd1;
    localparam logic [1:0] REQ_TARE   = 2'd2;

    // alarm codes
    localparam logic [1:0] ALARM_NONE  = 2'd0;
    localparam logic [1:0] ALARM_OVER  = 2'd1;
    localparam logic [1:0] ALARM_UNDER = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_EXTRA_PULSE = 2'd1;
    localparam logic [1:0] CFG_SCALE_RECIP = 2'd2;
    localparam logic [1:0] CFG_OVER_LIMIT  = 2'd3;

    // register reset values; recip is round(2^24 / 231.1)
    localparam logic [7:0]  RST_HALF_PERIOD = 8'd2;
    localparam logic [1:0]  RST_EXTRA_PULSE = 2'd3;
    localparam logic [23:0] RST_SCALE_RECIP = 24'd72597;
    localparam logic [15:0] RST_OVER_LIMIT  = 16'd5000;

    localparam int RAW_W    = 24;
    localparam int WEIGHT_W = 16;

    typedef struct packed {
        logic sck;
        logic busy;
        logic done;
        logic job_tare;
    } t_seq_stat;

endpackage

### hw/rtl/lcrt_seq.sv
// Serial link sequencer: request handling, ready wait, 24-bit clock-in and
// mode pulses. Depends on lcrt_pkg.
module lcrt_seq #(
    parameter int RAW_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [1:0]                 i_req,
    input  logic                       i_sdo,
    input  logic [7:0]                 i_half_period,
    input  logic [1:0]                 i_extra_pulses,
    output lcrt_pkg::t_seq_stat        o_stat,
    output logic [lcrt_pkg::RAW_W-1:0] o_raw
);
    import lcrt_pkg::*;

    localparam logic [4:0]          RawBitsC = 5'(RAW_BITS);
    localparam logic [RAW_BITS-1:0] MsbMask  = {1'b1, {(RAW_BITS-1){1'b0}}};

    logic [2:0]          r_phase, n_phase;
    logic [7:0]          r_tick,  n_tick;
    logic [4:0]          r_pulse, n_pulse;
    logic [RAW_BITS-1:0] r_shift, n_shift;
    logic                r_job_tare, n_job_tare;

    logic [7:0] w_hp;
    logic [4:0] w_ep;
    logic [7:0] w_tick_inc;
    logic       w_half_end;
    logic [7:0] w_tick_adv;
    logic [4:0] w_pulse_inc;

    assign w_hp        = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
    assign w_ep        = (i_extra_pulses == 2'd0) ? 5'd1 : {3'b000, i_extra_pulses};
    assign w_tick_inc  = r_tick + 8'd1;
    assign w_half_end  = (w_tick_inc >= w_hp) || (w_tick_inc == 8'd0);
    assign w_tick_adv  = w_half_end ? 8'd0 : w_tick_inc;
    assign w_pulse_inc = r_pulse + 5'd1;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_pulse    = r_pulse;
        n_shift    = r_shift;
        n_job_tare = r_job_tare;
        o_stat.sck      = 1'b0;
        o_stat.busy     = 1'b1;
        o_stat.done     = 1'b0;
        o_stat.job_tare = r_job_tare;
        case (r_phase)
            PH_IDLE: begin
                o_stat.busy = 1'b0;
                if (i_req == REQ_WEIGHT || i_req == REQ_TARE) begin
                    n_job_tare  = (i_req == REQ_TARE);
                    n_phase     = PH_WAIT;
                    n_tick      = 8'd0;
                    o_stat.busy = 1'b1;
                end
            end
            PH_WAIT: begin
                if (!i_sdo) begin
                    n_phase = PH_DHIGH;
                    n_tick  = 8'd0;
                    n_pulse = 5'd0;
                    n_shift = '0;
                end
            end
            PH_DHIGH: begin
                o_stat.sck = 1'b1;
                n_tick     = w_tick_adv;
                if (w_half_end) n_phase = PH_DLOW;
            end
            PH_DLOW: begin
                n_tick = w_tick_adv;
                if (w_half_end) begin
                    n_shift = {r_shift[RAW_BITS-2:0], i_sdo};
                    if (w_pulse_inc >= RawBitsC) begin
                        n_pulse = 5'd0;
                        n_phase = PH_PHIGH;
                    end else begin
                        n_pulse = w_pulse_inc;
                        n_phase = PH_DHIGH;
                    end
                end
            end
            PH_PHIGH: begin
                o_stat.sck = 1'b1;
                n_tick     = w_tick_adv;
                if (w_half_end) n_phase = PH_PLOW;
            end
            PH_PLOW: begin
                n_tick = w_tick_adv;
                if (w_half_end) begin
                    if (w_pulse_inc < w_ep) begin
                        n_pulse = w_pulse_inc;
                        n_phase = PH_PHIGH;
                    end else begin
                        n_pulse     = 5'd0;
                        n_phase     = PH_IDLE;
                        o_stat.busy = 1'b0;
                        o_stat.done = 1'b1;
                    end
                end
            end
            default: begin
                n_phase     = PH_IDLE;
                n_tick      = 8'd0;
                n_pulse     = 5'd0;
                o_stat.busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= 8'd0;
            r_pulse    <= 5'd0;
            r_shift    <= '0;
            r_job_tare <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_pulse    <= n_pulse;
            r_shift    <= n_shift;
            r_job_tare <= n_job_tare;
        end
    end

    // offset binary: top data bit inverted
    assign o_raw = RAW_W'(r_shift ^ MsbMask);

`ifndef ASSERT_OFF
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse < RawBitsC)
        else $error("pulse count out of range");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_stat.done |=> r_phase == PH_IDLE)
        else $error("completion did not return to idle");
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DHIGH || r_phase == PH_PHIGH) |-> o_stat.busy && !o_stat.done)
        else $error("clock-high phase reported not busy");
`endif

endmodule

### hw/rtl/lcrt_scale.sv
// Tare store and weight scaling: net count times Q0.24 reciprocal, with
// saturation and alarms. Depends on lcrt_pkg.
module lcrt_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lcrt_pkg::RAW_W-1:0]    i_raw,
    input  logic                          i_commit_tare,
    input  logic [23:0]                   i_recip,
    input  logic [15:0]                   i_limit,
    output logic [lcrt_pkg::WEIGHT_W-1:0] o_weight,
    output logic [1:0]                    o_alarm
);
    import lcrt_pkg::*;

    logic [RAW_W-1:0] r_tare;
    logic [23:0]      r_prod_hi;
    logic             r_below;
    logic [RAW_W-1:0] w_net;
    logic [47:0]      w_prod;

    // raw is stable through the pulse phases, so the product is ready ahead
    // of the completing tick
    assign w_net  = i_raw - r_tare;
    assign w_prod = w_net * i_recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare <= '0;
        end else if (i_commit_tare) begin
            r_tare <= i_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_hi <= w_prod[47:24];
        r_below   <= (i_raw < r_tare);
    end

    always_comb begin
        if (r_below) begin
            o_weight = '0;
            o_alarm  = ALARM_UNDER;
        end else if (r_prod_hi[23:16] != 8'd0) begin
            o_weight = '1;
            o_alarm  = ALARM_OVER;
        end else begin
            o_weight = r_prod_hi[15:0];
            o_alarm  = (r_prod_hi[15:0] > i_limit) ? ALARM_OVER : ALARM_NONE;
        end
    end

`ifndef ASSERT_OFF
    a_under_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_alarm == ALARM_UNDER |-> o_weight == '0)
        else $error("underload with non-zero weight");
    a_tare_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_commit_tare |=> $stable(r_tare))
        else $error("tare changed without commit");
    a_sat_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_below && r_prod_hi[23:16] != 8'd0 |-> o_alarm == ALARM_OVER)
        else $error("saturation without overload alarm");
`endif

endmodule

### hw/rtl/load_cell_adc_readout_with_tare_core.sv
// Load-cell ADC readout core: stream wrapper, configuration registers, sequencer
// and scaling. Depends on lcrt_pkg, lcrt_seq and lcrt_scale.
//
// Each input word is one tick of a bit-banged two-wire ADC link; each tick gives
// exactly one output word. A weight or tare request (tuser) starts a readout:
// the clock is held low until the data pin reads low, then RAW_BITS bits are
// clocked in MSB first (sampled at the end of each low half period), followed
// by 1..3 mode pulses. On the completing tick the word carries the offset-binary
// reading; a tare job stores it, a weight job subtracts the tare and scales by
// the Q0.24 reciprocal, saturating at 65535 with the overload alarm. Requests
// while busy are ignored. The drive level for the serial clock pin is the sck
// bit of the output word. Throughput is one tick per clock unless the output
// stalls: an input register feeds the sequencer, and the output register takes
// the result in the same cycle. The net product is prepared in a register
// during the mode pulses, so the 24x24 multiplier is off the completing tick's
// path. The user must write configuration only while no readout is in
// progress; the block itself does not enforce it.
module load_cell_adc_readout_with_tare_core #(
    parameter int RAW_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    // input ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] sdo_level, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // output words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [0] sck_level, [1] busy_res, [2] result_valid,
                                        // [26:3] raw_value, [42:27] weight,
                                        // [44:43] alarm, rest zero
    output logic        m_axis_tuser    // [0] result_was_tare
);
    import lcrt_pkg::*;

    // configuration
    logic [7:0]  r_half_period;
    logic [1:0]  r_extra_pulses;
    logic [23:0] r_recip;
    logic [15:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period  <= RST_HALF_PERIOD;
            r_extra_pulses <= RST_EXTRA_PULSE;
            r_recip        <= RST_SCALE_RECIP;
            r_limit        <= RST_OVER_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HALF_PERIOD: r_half_period  <= i_cfg_wdata[7:0];
                CFG_EXTRA_PULSE: r_extra_pulses <= i_cfg_wdata[1:0];
                CFG_SCALE_RECIP: r_recip        <= i_cfg_wdata;
                CFG_OVER_LIMIT:  r_limit        <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_req;
    logic       r_in_sdo;
    logic       w_step;

    // a tick is processed when the output register is free or being drained
    assign w_step        = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req <= s_axis_tuser;
            r_in_sdo <= s_axis_tdata[0];
        end
    end

    // sequencer and scaling
    t_seq_stat              w_stat;
    logic [RAW_W-1:0]       w_raw;
    logic [WEIGHT_W-1:0]    w_weight;
    logic [1:0]             w_alarm;

    lcrt_seq #(
        .RAW_BITS(RAW_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_req         (r_in_req),
        .i_sdo         (r_in_sdo),
        .i_half_period (r_half_period),
        .i_extra_pulses(r_extra_pulses),
        .o_stat        (w_stat),
        .o_raw         (w_raw)
    );

    lcrt_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_raw        (w_raw),
        .i_commit_tare(w_step && w_stat.done && w_stat.job_tare),
        .i_recip      (r_recip),
        .i_limit      (r_limit),
        .o_weight     (w_weight),
        .o_alarm      (w_alarm)
    );

    // output register: result fields are zero except on the completing tick,
    // and a tare completion reports weight 0 with no alarm
    logic                r_out_valid;
    logic                r_sck, r_busy, r_done, r_was_tare;
    logic [RAW_W-1:0]    r_raw;
    logic [WEIGHT_W-1:0] r_weight;
    logic [1:0]          r_alarm;
    logic                w_weigh_done;

    assign w_weigh_done = w_stat.done && !w_stat.job_tare;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_sck      <= w_stat.sck;
            r_busy     <= w_stat.busy;
            r_done     <= w_stat.done;
            r_was_tare <= w_stat.done && w_stat.job_tare;
            r_raw      <= w_stat.done ? w_raw : '0;
            r_weight   <= w_weigh_done ? w_weight : '0;
            r_alarm    <= w_weigh_done ? w_alarm : ALARM_NONE;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_was_tare;
    assign m_axis_tdata  = {3'b000, r_alarm, r_weight, r_raw, r_done, r_busy, r_sck};

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && !m_axis_tdata[0])
        else $error("completion word shows busy or clock high");
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[44:3] == '0 && !m_axis_tuser)
        else $error("result fields set outside a completion");
    a_alarm_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[44:43] != 2'd3)
        else $error("undefined alarm code");
    a_tare_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[44:27] == '0)
        else $error("tare word with weight or alarm");
`endif

endmodule
